### rtl/mga_pkg.sv
// shared types and constants of the masked gram accumulator
package mga_pkg;

   localparam int VALUE_W    = 32;
   localparam int SUM_W      = 64;
   localparam int INDEX_W    = 3;
   localparam int COV_FIELDS = 4;

   localparam logic [INDEX_W-1:0] COV_RESET = 3'd4;

   localparam logic KIND_GRAM  = 1'b0;
   localparam logic KIND_CROSS = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic                    vld;
      logic                    last;
      logic                    kind;
      logic [INDEX_W-1:0]      row;
      logic [INDEX_W-1:0]      col;
      logic signed [SUM_W-1:0] value;
   } slot_type;

   typedef struct packed {
      logic adv;    // pipe moves forward
      logic acc;    // accumulate stage holds a sample
      logic keep;   // that sample is not missing
      logic load;   // that sample closes the locus
      logic shift;  // emission chain moves one place toward the output
   } ctl_type;

endpackage

### rtl/mga_req_if.sv
// sample channel
interface mga_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mga_pkg::VALUE_W-1:0]  genotype;
   logic                                genotype_missing;
   logic signed [mga_pkg::VALUE_W-1:0]  phenotype;
   logic signed [mga_pkg::VALUE_W-1:0]  cov_a;
   logic signed [mga_pkg::VALUE_W-1:0]  cov_b;
   logic signed [mga_pkg::VALUE_W-1:0]  cov_c;
   logic signed [mga_pkg::VALUE_W-1:0]  cov_d;
   logic                                last_sample;

   modport source (output valid, genotype, genotype_missing, phenotype,
                   cov_a, cov_b, cov_c, cov_d, last_sample, input ready);
   modport sink   (input valid, genotype, genotype_missing, phenotype,
                   cov_a, cov_b, cov_c, cov_d, last_sample, output ready);
endinterface

### rtl/mga_rsp_if.sv
// result channel
interface mga_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [mga_pkg::INDEX_W-1:0]        row_index;
   logic [mga_pkg::INDEX_W-1:0]        col_index;
   logic signed [mga_pkg::SUM_W-1:0]   sum_value;
   logic                               last_result;

   modport source (output valid, kind, row_index, col_index, sum_value,
                   last_result, input ready);
   modport sink   (input valid, kind, row_index, col_index, sum_value,
                   last_result, output ready);
endinterface

### rtl/mga_csr_if.sv
// configuration write channel
interface mga_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mga_pkg::INDEX_W-1:0]   covariates_in_use;

   modport source (output valid, covariates_in_use, input ready);
   modport sink   (input valid, covariates_in_use, output ready);
endinterface

### rtl/masked_gram_accumulator_top.sv
// top level of the masked gram accumulator
// Takes one sample per clock while the pipe is not held. A sample passes an
// operand register, a product register in every cell and then the saturating
// add into the sum register. Each X'X entry and each X'y entry has its own
// cell. On the last sample of a locus every cell copies its finished sum into
// its emission slot and clears; the slots form a chain that moves one place
// per cycle toward the output register while that register can take a
// result. Entries outside the configured column count travel as empty slots
// and give no result beat. Samples of the next locus keep flowing during the
// drain; only a further last sample that reaches the add stage before the
// chain is empty holds the pipe, which sets the rate for loci shorter than
// the drain. The output register lets a result wait without stopping the
// cells.
module masked_gram_accumulator_top #(
   parameter int MAX_COVARIATES = 4
) (
   input logic      clock,
   input logic      reset,
   mga_req_if.sink  req,
   mga_rsp_if.source rsp,
   mga_csr_if.sink  csr
);

   localparam int COV_LIMIT = (MAX_COVARIATES < mga_pkg::COV_FIELDS) ?
                              MAX_COVARIATES : mga_pkg::COV_FIELDS;
   localparam int NCOL      = COV_LIMIT + 1;
   localparam int NGRAM     = (NCOL * (NCOL + 1)) / 2;
   localparam int NCELL     = NGRAM + NCOL;

   logic [mga_pkg::INDEX_W-1:0] cov_ff, cov_in, n_eff;

   logic signed [mga_pkg::VALUE_W-1:0] cov_all [mga_pkg::COV_FIELDS];
   logic signed [mga_pkg::VALUE_W-1:0] x_in [NCOL];
   logic signed [mga_pkg::VALUE_W-1:0] a_x_ff [NCOL];
   logic signed [mga_pkg::VALUE_W-1:0] a_y_ff;
   logic a_vld_ff, a_keep_ff, a_last_ff;
   logic b_vld_ff, b_keep_ff, b_last_ff;

   logic              adv, accept, chain_busy;
   mga_pkg::ctl_type  ctl;
   mga_pkg::slot_type cell_slot [NCELL];
   mga_pkg::slot_type out_ff, out_in;
   logic [NCELL-1:0]  busy_vec, last_vec;

   // configuration
   assign csr.ready = 1'b1;

   always_comb begin
      cov_in = cov_ff;
      if (csr.valid && csr.ready) begin
         cov_in = csr.covariates_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cov_ff <= mga_pkg::COV_RESET;
      end else begin
         cov_ff <= cov_in;
      end
   end

   // columns beyond the built ones are not emitted
   assign n_eff = (cov_ff > mga_pkg::INDEX_W'(COV_LIMIT)) ?
                  mga_pkg::INDEX_W'(COV_LIMIT) : cov_ff;

   // pipe control
   assign chain_busy = |busy_vec;
   assign adv        = !(b_vld_ff && b_last_ff && chain_busy);
   assign req.ready  = adv;
   assign accept     = req.valid && adv;

   assign ctl.adv   = adv;
   assign ctl.acc   = adv && b_vld_ff;
   assign ctl.keep  = b_keep_ff;
   assign ctl.load  = adv && b_vld_ff && b_last_ff;
   assign ctl.shift = !out_ff.vld || rsp.ready;

   assign cov_all[0] = req.cov_a;
   assign cov_all[1] = req.cov_b;
   assign cov_all[2] = req.cov_c;
   assign cov_all[3] = req.cov_d;

   genvar gi, gj;
   generate
      for (gi = 0; gi < NCOL; gi++) begin : g_x
         if (gi == 0) begin : g_geno
            assign x_in[gi] = req.genotype;
         end else begin : g_cov
            assign x_in[gi] = cov_all[gi-1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_keep_ff <= !req.genotype_missing;
         a_last_ff <= req.last_sample;
         a_y_ff    <= req.phenotype;
         a_x_ff    <= x_in;
         b_keep_ff <= a_keep_ff;
         b_last_ff <= a_last_ff;
      end
   end

   // cell row: gram cells in row-major upper-triangle order, then cross cells
   generate
      for (gi = 0; gi < NCOL; gi++) begin : g_row
         for (gj = gi; gj < NCOL; gj++) begin : g_gram
            localparam int P = gi * NCOL - (gi * (gi - 1)) / 2 + (gj - gi);
            mga_pkg::tag_type  tag;
            mga_pkg::slot_type nbr;
            assign tag.kind = mga_pkg::KIND_GRAM;
            assign tag.row  = mga_pkg::INDEX_W'(gi);
            assign tag.col  = mga_pkg::INDEX_W'(gj);
            assign nbr      = cell_slot[P+1];
            mga_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctl       (ctl),
               .op_a      (a_x_ff[gi]),
               .op_b      (a_x_ff[gj]),
               .tag       (tag),
               .load_vld  (mga_pkg::INDEX_W'(gj) <= n_eff),
               .load_last (1'b0),
               .nbr_in    (nbr),
               .slot_out  (cell_slot[P])
            );
         end
         if (1) begin : g_cross
            localparam int P = NGRAM + gi;
            mga_pkg::tag_type  tag;
            mga_pkg::slot_type nbr;
            assign tag.kind = mga_pkg::KIND_CROSS;
            assign tag.row  = mga_pkg::INDEX_W'(gi);
            assign tag.col  = '0;
            if (P == NCELL - 1) begin : g_end
               assign nbr = '0;
            end else begin : g_mid
               assign nbr = cell_slot[P+1];
            end
            mga_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctl       (ctl),
               .op_a      (a_x_ff[gi]),
               .op_b      (a_y_ff),
               .tag       (tag),
               .load_vld  (mga_pkg::INDEX_W'(gi) <= n_eff),
               .load_last (mga_pkg::INDEX_W'(gi) == n_eff),
               .nbr_in    (nbr),
               .slot_out  (cell_slot[P])
            );
         end
      end
      for (gi = 0; gi < NCELL; gi++) begin : g_busy
         assign busy_vec[gi] = cell_slot[gi].vld;
         assign last_vec[gi] = cell_slot[gi].vld && cell_slot[gi].last;
      end
   endgenerate

   // output register, fed from the head of the chain
   always_comb begin
      out_in = out_ff;
      if (ctl.shift) begin
         out_in = cell_slot[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid       = out_ff.vld;
   assign rsp.kind        = out_ff.kind;
   assign rsp.row_index   = out_ff.row;
   assign rsp.col_index   = out_ff.col;
   assign rsp.sum_value   = out_ff.value;
   assign rsp.last_result = out_ff.last;

   // a locus closing always puts at least the (0,0) entry at the chain head
   a_load_head: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> cell_slot[0].vld)
      else $error("chain head empty after locus load");

   // only one pending entry per locus may carry the end mark
   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $countones(last_vec) <= 1)
      else $error("more than one end mark in chain");

   // the end mark belongs to the last cross entry
   a_last_cross: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_result) |-> (rsp.kind == mga_pkg::KIND_CROSS))
      else $error("end mark on a gram entry");

   // a held last sample releases only once the chain has drained
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && b_last_ff && !adv) |=> (b_vld_ff && b_last_ff))
      else $error("closing sample lost while chain busy");

endmodule

### rtl/mga_cell.sv
// one accumulator cell: multiplier, saturating sum and one emission chain slot
module mga_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mga_pkg::ctl_type                     ctl,
   input  logic signed [mga_pkg::VALUE_W-1:0]   op_a,
   input  logic signed [mga_pkg::VALUE_W-1:0]   op_b,
   input  mga_pkg::tag_type                     tag,
   input  logic                                 load_vld,
   input  logic                                 load_last,
   input  mga_pkg::slot_type                    nbr_in,
   output mga_pkg::slot_type                    slot_out
);

   logic signed [mga_pkg::SUM_W-1:0] prod_ff, prod_in;
   logic signed [mga_pkg::SUM_W-1:0] sum_ff, sum_in, sum_add;
   mga_pkg::slot_type                slot_ff, slot_in;

   function automatic logic signed [mga_pkg::SUM_W-1:0] sat_add(
      input logic signed [mga_pkg::SUM_W-1:0] a,
      input logic signed [mga_pkg::SUM_W-1:0] b
   );
      logic signed [mga_pkg::SUM_W-1:0] s;
      s = a + b;
      if ((a[mga_pkg::SUM_W-1] == b[mga_pkg::SUM_W-1]) &&
          (s[mga_pkg::SUM_W-1] != a[mga_pkg::SUM_W-1])) begin
         s = a[mga_pkg::SUM_W-1] ? {1'b1, {(mga_pkg::SUM_W-1){1'b0}}}
                                 : {1'b0, {(mga_pkg::SUM_W-1){1'b1}}};
      end
      return s;
   endfunction

   // q16.16 times q16.16 is exact in q32.32
   assign prod_in = op_a * op_b;

   always_comb begin
      sum_add = ctl.keep ? sat_add(sum_ff, prod_ff) : sum_ff;
      sum_in  = sum_ff;
      if (ctl.acc) begin
         sum_in = ctl.load ? '0 : sum_add;
      end
      slot_in = slot_ff;
      if (ctl.load) begin
         slot_in.vld   = load_vld;
         slot_in.last  = load_last;
         slot_in.kind  = tag.kind;
         slot_in.row   = tag.row;
         slot_in.col   = tag.col;
         slot_in.value = sum_add;
      end else if (ctl.shift) begin
         slot_in = nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         slot_ff.vld <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule

### dv/masked_gram_accumulator_top_tb.sv
// testbench of the masked gram accumulator: directed table, random loci, self-checking
`timescale 1ns / 1ps
module masked_gram_accumulator_top_tb;

   localparam int VALUE_W      = mga_pkg::VALUE_W;
   localparam int SUM_W        = mga_pkg::SUM_W;
   localparam int INDEX_W      = mga_pkg::INDEX_W;
   localparam int MAX_COV      = 4;
   localparam int COL_LIMIT    = (MAX_COV < mga_pkg::COV_FIELDS) ? MAX_COV
                                                                 : mga_pkg::COV_FIELDS;
   localparam int NCOL         = COL_LIMIT + 1;
   localparam int QUIET_CYCLES = 40;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 40;
   localparam int CALM_PHASE   = 5;

   localparam logic signed [VALUE_W-1:0] NEG = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] POS = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] ONE = 32'sh0001_0000;
   localparam logic signed [SUM_W-1:0]   SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0]   SUM_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [INDEX_W-1:0] PHASE_COV [0:PHASES-1] =
      '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd4, 3'd0};

   typedef struct packed {
      logic signed [VALUE_W-1:0] genotype;
      logic                      missing;
      logic signed [VALUE_W-1:0] phenotype;
      logic signed [VALUE_W-1:0] cov_a;
      logic signed [VALUE_W-1:0] cov_b;
      logic signed [VALUE_W-1:0] cov_c;
      logic signed [VALUE_W-1:0] cov_d;
      logic                      last;
   } sample_type;

   typedef struct packed {
      logic                    cfg_write;
      logic [INDEX_W-1:0]      cfg_value;
      sample_type              smp;
      logic                    typed;      // every sum of this emission is typed_sum
      logic signed [SUM_W-1:0] typed_sum;
   } plan_row_type;

   typedef struct packed {
      logic                    kind;
      logic [INDEX_W-1:0]      row;
      logic [INDEX_W-1:0]      col;
      logic signed [SUM_W-1:0] value;
      logic                    last;
   } sum_beat_type;

   localparam int PLAN_ROWS = 19;
   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      // right after reset: only a missing last sample, so all sums are zero
      '{1'b0, 3'd0, '{ONE, 1'b1, POS, POS, POS, POS, POS, 1'b1}, 1'b1, 64'sh0},
      '{1'b0, 3'd0, '{NEG, 1'b0, NEG, NEG, NEG, NEG, NEG, 1'b1}, 1'b1,
        64'sh4000_0000_0000_0000},
      '{1'b0, 3'd0, '{POS, 1'b0, POS, POS, POS, POS, POS, 1'b1}, 1'b1,
        64'sh3FFF_FFFF_0000_0001},
      // two most-negative samples overflow every sum upward
      '{1'b0, 3'd0, '{NEG, 1'b0, NEG, NEG, NEG, NEG, NEG, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{NEG, 1'b0, NEG, NEG, NEG, NEG, NEG, 1'b1}, 1'b1, SUM_MAX},
      // mixed signs drive the genotype's off-diagonal and cross sums down to the floor
      '{1'b0, 3'd0, '{NEG, 1'b0, POS, POS, POS, POS, POS, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{NEG, 1'b0, POS, POS, POS, POS, POS, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{NEG, 1'b0, POS, POS, POS, POS, POS, 1'b1}, 1'b0, 64'sh0},
      '{1'b1, 3'd0, '{32'sh0003_8000, 1'b0, 32'shFFFF_0000, 32'sh1234_5678,
        32'sh0, 32'sh0, 32'sh0, 1'b1}, 1'b0, 64'sh0},
      // register above the covariate count saturates to four
      '{1'b1, 3'd7, '{32'shFFFE_4000, 1'b0, 32'sh0002_0000, 32'sh0000_8000,
        32'shFFFF_C000, 32'sh7FFF_0000, NEG, 1'b1}, 1'b0, 64'sh0},
      '{1'b1, 3'd1, '{32'sh0001_8000, 1'b0, POS, NEG, 32'sh0000_0001,
        32'sh0, 32'sh0, 1'b1}, 1'b0, 64'sh0},
      // locus opened at two covariates, closed after a write of five
      '{1'b1, 3'd2, '{32'sh0002_0000, 1'b0, 32'sh0010_0000, 32'sh0003_0000,
        32'shFFFD_0000, 32'sh0004_0000, 32'sh0005_0000, 1'b0}, 1'b0, 64'sh0},
      '{1'b1, 3'd5, '{POS, 1'b1, POS, POS, POS, POS, POS, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{NEG, 1'b1, NEG, ONE, ONE, ONE, ONE, 1'b1}, 1'b0, 64'sh0},
      '{1'b1, 3'd3, '{32'sh5555_5555, 1'b0, 32'shAAAA_AAAA, 32'sh5555_5555,
        32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{32'sh0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1},
        1'b0, 64'sh0},
      '{1'b1, 3'd6, '{32'shFFFF_FFFF, 1'b0, 32'sh0000_0001, 32'shFFFF_FFFF,
        32'sh0000_0001, ONE, 32'shFFFF_0000, 1'b1}, 1'b0, 64'sh0},
      '{1'b1, 3'd4, '{32'shAAAA_AAAA, 1'b0, 32'sh5555_5555, 32'shAAAA_AAAA,
        32'sh5555_5555, 32'shF0F0_F0F0, 32'sh0F0F_0F0F, 1'b0}, 1'b0, 64'sh0},
      '{1'b0, 3'd0, '{32'sh0000_0001, 1'b0, NEG, POS, NEG, POS, NEG, 1'b1},
        1'b0, 64'sh0}
   };

   logic clock = 1'b0;
   logic reset;
   logic calm;
   int   mismatches = 0;

   mga_req_if req_bus ();
   mga_rsp_if rsp_bus ();
   mga_csr_if csr_bus ();

   masked_gram_accumulator_top #(.MAX_COVARIATES(MAX_COV)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // own copy of the sums and the register
   logic signed [SUM_W-1:0] gram_sum  [0:NCOL-1][0:NCOL-1];
   logic signed [SUM_W-1:0] cross_sum [0:NCOL-1];
   logic [INDEX_W-1:0]      cov_setting;
   sum_beat_type            pending_sums [$];

   always #5 clock = ~clock;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = a + b;
      if (s[SUM_W] != s[SUM_W-1])
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      return s[SUM_W-1:0];
   endfunction

   // append one expected result beat
   function automatic void queue_sum(input sum_beat_type b);
      pending_sums = {pending_sums, b};
   endfunction

   // fold one accepted sample into the sums; on the last one queue the whole locus
   function automatic void take_sample(input sample_type s, input logic typed,
                                       input logic signed [SUM_W-1:0] typed_sum);
      logic signed [VALUE_W-1:0] x [0:NCOL-1];
      logic signed [SUM_W-1:0]   prod;
      int                        i, j, n;
      x[0] = s.genotype;
      if (NCOL > 1) x[1] = s.cov_a;
      if (NCOL > 2) x[2] = s.cov_b;
      if (NCOL > 3) x[3] = s.cov_c;
      if (NCOL > 4) x[4] = s.cov_d;
      if (!s.missing) begin
         for (i = 0; i < NCOL; i++) begin
            for (j = i; j < NCOL; j++) begin
               prod = x[i] * x[j];
               gram_sum[i][j] = sat_add(gram_sum[i][j], prod);
            end
            prod = x[i] * s.phenotype;
            cross_sum[i] = sat_add(cross_sum[i], prod);
         end
      end
      if (!s.last)
         return;
      n = ((cov_setting > COL_LIMIT) ? COL_LIMIT : int'(cov_setting)) + 1;
      for (i = 0; i < n; i++)
         for (j = i; j < n; j++)
            queue_sum('{mga_pkg::KIND_GRAM, INDEX_W'(i), INDEX_W'(j),
                        typed ? typed_sum : gram_sum[i][j], 1'b0});
      for (i = 0; i < n; i++)
         queue_sum('{mga_pkg::KIND_CROSS, INDEX_W'(i), INDEX_W'(0),
                     typed ? typed_sum : cross_sum[i], 1'b0});
      pending_sums[pending_sums.size()-1].last = 1'b1;
      for (i = 0; i < NCOL; i++) begin
         cross_sum[i] = '0;
         for (j = 0; j < NCOL; j++)
            gram_sum[i][j] = '0;
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return NEG;
         1: return POS;
         2: return '0;
         3: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_sample(input sample_type s, input logic typed,
                              input logic signed [SUM_W-1:0] typed_sum);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.genotype         <= s.genotype;
      req_bus.genotype_missing <= s.missing;
      req_bus.phenotype        <= s.phenotype;
      req_bus.cov_a            <= s.cov_a;
      req_bus.cov_b            <= s.cov_b;
      req_bus.cov_c            <= s.cov_c;
      req_bus.cov_d            <= s.cov_d;
      req_bus.last_sample      <= s.last;
      do @(posedge clock); while (!req_bus.ready);
      take_sample(s, typed, typed_sum);
   endtask

   // hold the sender until every queued result has come back, optionally let the pipe drain
   task automatic wait_quiet(input logic settle);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_sums.size() != 0)
         @(negedge clock);
      if (settle)
         repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_cov(input logic [INDEX_W-1:0] v);
      wait_quiet(1'b1);
      csr_bus.valid             <= 1'b1;
      csr_bus.covariates_in_use <= v;
      do @(posedge clock); while (!csr_bus.ready);
      cov_setting = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= calm || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin : check_results
      sum_beat_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.kind, rsp_bus.row_index, rsp_bus.col_index,
                 rsp_bus.sum_value, rsp_bus.last_result};
         if (pending_sums.size() == 0) begin
            $display("%0t: result beat expected none actual kind %0d row %0d col %0d sum %h",
                     $time, got.kind, got.row, got.col, got.value);
            mismatches++;
         end else begin
            want = pending_sums.pop_front();
            if (got.kind !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
               mismatches++;
            end
            if (got.row !== want.row) begin
               $display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
               mismatches++;
            end
            if (got.col !== want.col) begin
               $display("%0t: col_index expected %0d actual %0d", $time, want.col, got.col);
               mismatches++;
            end
            if (got.value !== want.value) begin
               $display("%0t: sum_value (%0d,%0d) expected %h actual %h",
                        $time, want.row, want.col, want.value, got.value);
               mismatches++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last_result expected %0d actual %0d",
                        $time, want.last, got.last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("masked_gram_accumulator_top_tb: errors");
      $finish;
   end

   initial begin
      sample_type s;
      int         k, ph, len, sent;
      reset      = 1'b1;
      calm       = 1'b0;
      req_bus.valid            = 1'b0;
      req_bus.genotype         = '0;
      req_bus.genotype_missing = 1'b0;
      req_bus.phenotype        = '0;
      req_bus.cov_a            = '0;
      req_bus.cov_b            = '0;
      req_bus.cov_c            = '0;
      req_bus.cov_d            = '0;
      req_bus.last_sample      = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.covariates_in_use = '0;
      cov_setting = mga_pkg::COV_RESET;
      for (k = 0; k < NCOL; k++) begin
         cross_sum[k] = '0;
         for (len = 0; len < NCOL; len++)
            gram_sum[k][len] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < PLAN_ROWS; k++) begin
         if (PLAN[k].cfg_write)
            write_cov(PLAN[k].cfg_value);
         send_sample(PLAN[k].smp, PLAN[k].typed, PLAN[k].typed_sum);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         write_cov((ph == PHASES - 1) ? INDEX_W'($urandom_range(7)) : PHASE_COV[ph]);
         calm = (ph == CALM_PHASE);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(24) == 0)
               wait_quiet(1'b0);
            // mostly short loci, now and then a long one that piles up toward saturation
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            for (k = 0; k < len; k++) begin
               s.genotype  = pick_value();
               s.missing   = ($urandom_range(4) == 0);
               s.phenotype = pick_value();
               s.cov_a     = pick_value();
               s.cov_b     = pick_value();
               s.cov_c     = pick_value();
               s.cov_d     = pick_value();
               s.last      = (k == len - 1);
               send_sample(s, 1'b0, '0);
            end
            sent += len;
         end
      end
      calm = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_sums.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("masked_gram_accumulator_top_tb: clean");
      else
         $display("masked_gram_accumulator_top_tb: errors");
      $finish;
   end

endmodule

### masked_gram_accumulator_top.f
rtl/mga_pkg.sv
rtl/mga_req_if.sv
rtl/mga_rsp_if.sv
rtl/mga_csr_if.sv
rtl/mga_cell.sv
rtl/masked_gram_accumulator_top.sv
dv/masked_gram_accumulator_top_tb.sv
